@@ hw/rtl/kvlp_pkg.sv @@
// Shared types, constants and decode functions for the key/value line parser.
// Used by the channel interfaces, the parse core, the result buffer and the top level.
// No dependencies.
`default_nettype none

package kvlp_pkg;

   localparam int unsigned MAX_VALUES = 16;
   localparam int unsigned LINE_LIMIT = 1024;

   localparam int CHAR_W = 8;
   localparam int ROLE_W = 3;
   localparam int SLOT_W = 4;
   localparam int POS_W  = 10;
   localparam int STAT_W = 3;
   localparam int LEN_W  = 11;
   localparam int CNT_W  = 5;

   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_LIMIT);
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(LINE_LIMIT - 1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_VALUES);

   localparam logic [CHAR_W-1:0] CHAR_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_BLANK  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE  = 8'h22;
   localparam logic [CHAR_W-1:0] CHAR_EQUALS = 8'h3D;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NOTE, ST_KBEG, ST_KRUN, ST_KGAP,
      ST_VOPEN, ST_VBEG_A, ST_VRUN, ST_VGAP_PRE, ST_VGAP_POST, ST_VBEG_B,
      ST_QOPEN_A, ST_QOPEN_B, ST_QFIRST, ST_QRUN, ST_QCLOSE,
      ST_ERR_KEYCH, ST_ERR_NOKEY, ST_ERR_KEYBLANK, ST_ERR_VALCH,
      ST_ERR_NOQUOTE, ST_ERR_AFTERQ, ST_DONE
   } parse_state_type;

   typedef enum logic [2:0] {
      CLS_HASH, CLS_BLANK, CLS_COMMA, CLS_QUOTE, CLS_EQUALS, CLS_END, CLS_OTHER
   } char_class_type;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_NONE, ROLE_KEY_START, ROLE_KEY_MORE, ROLE_VALUE_OPENED,
      ROLE_VALUE_FIRST, ROLE_VALUE_MORE, ROLE_OPENED_FIRST
   } role_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK, STAT_BAD_KEY_CHAR, STAT_NO_KEY, STAT_KEY_BLANK,
      STAT_BAD_VALUE_CHAR, STAT_NO_END_QUOTE, STAT_BAD_AFTER_QUOTE, STAT_TOO_MANY
   } status_type;

   typedef struct packed {
      role_type           char_role;
      logic [SLOT_W-1:0]  value_index;
      logic [POS_W-1:0]   position;
      logic               finished;
      status_type         status;
      logic [LEN_W-1:0]   key_length;
      logic [CNT_W-1:0]   value_count;
      logic [LEN_W-1:0]   value_length;
   } rsp_payload_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] code,
                                               input logic line_end);
      char_class_type cls;
      if (line_end) begin
         cls = CLS_END;
      end else if (code == CHAR_HASH) begin
         cls = CLS_HASH;
      end else if (code == CHAR_BLANK) begin
         cls = CLS_BLANK;
      end else if (code == CHAR_COMMA) begin
         cls = CLS_COMMA;
      end else if (code == CHAR_QUOTE) begin
         cls = CLS_QUOTE;
      end else if (code == CHAR_EQUALS) begin
         cls = CLS_EQUALS;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

   // Transition table. Error and done states never look ahead (the line is
   // closed by then), so they share the idle row.
   function automatic parse_state_type next_state(input parse_state_type s,
                                                  input char_class_type c);
      parse_state_type ns;
      ns = ST_IDLE;
      unique case (s) inside
         ST_NOTE: begin
            ns = (c == CLS_END) ? ST_DONE : ST_NOTE;
         end
         ST_KBEG, ST_KRUN, ST_KGAP: begin
            unique case (c) inside
               CLS_HASH:             ns = ST_NOTE;
               CLS_BLANK:            ns = ST_KGAP;
               CLS_COMMA, CLS_QUOTE: ns = ST_ERR_KEYCH;
               CLS_EQUALS:           ns = ST_VOPEN;
               CLS_END:              ns = ST_DONE;
               default:              ns = (s == ST_KGAP) ? ST_ERR_KEYBLANK : ST_KRUN;
            endcase
         end
         ST_VOPEN, ST_VGAP_PRE: begin
            unique case (c) inside
               CLS_HASH:   ns = ST_NOTE;
               CLS_BLANK:  ns = ST_VGAP_PRE;
               CLS_COMMA:  ns = ST_VOPEN;
               CLS_QUOTE:  ns = ST_QOPEN_A;
               CLS_EQUALS: ns = ST_ERR_VALCH;
               CLS_END:    ns = ST_DONE;
               default:    ns = ST_VBEG_A;
            endcase
         end
         ST_VBEG_A, ST_VRUN, ST_VBEG_B: begin
            unique case (c) inside
               CLS_HASH:              ns = ST_NOTE;
               CLS_BLANK:             ns = ST_VGAP_POST;
               CLS_COMMA:             ns = ST_VOPEN;
               CLS_QUOTE, CLS_EQUALS: ns = ST_ERR_VALCH;
               CLS_END:               ns = ST_DONE;
               default:               ns = ST_VRUN;
            endcase
         end
         ST_VGAP_POST: begin
            unique case (c) inside
               CLS_HASH:   ns = ST_NOTE;
               CLS_BLANK:  ns = ST_VGAP_POST;
               CLS_COMMA:  ns = ST_VOPEN;
               CLS_QUOTE:  ns = ST_QOPEN_B;
               CLS_EQUALS: ns = ST_ERR_VALCH;
               CLS_END:    ns = ST_DONE;
               default:    ns = ST_VBEG_B;
            endcase
         end
         ST_QOPEN_A, ST_QOPEN_B, ST_QFIRST, ST_QRUN: begin
            unique case (c) inside
               CLS_QUOTE: ns = ST_QCLOSE;
               CLS_END:   ns = ST_ERR_NOQUOTE;
               default: begin
                  ns = (s == ST_QFIRST || s == ST_QRUN) ? ST_QRUN : ST_QFIRST;
               end
            endcase
         end
         ST_QCLOSE: begin
            unique case (c) inside
               CLS_HASH:  ns = ST_NOTE;
               CLS_BLANK: ns = ST_VGAP_POST;
               CLS_COMMA: ns = ST_VOPEN;
               CLS_END:   ns = ST_DONE;
               default:   ns = ST_ERR_AFTERQ;
            endcase
         end
         default: begin
            unique case (c) inside
               CLS_HASH:             ns = ST_NOTE;
               CLS_BLANK:            ns = ST_IDLE;
               CLS_COMMA, CLS_QUOTE: ns = ST_ERR_KEYCH;
               CLS_EQUALS:           ns = ST_ERR_NOKEY;
               CLS_END:              ns = ST_DONE;
               default:              ns = ST_KBEG;
            endcase
         end
      endcase
      return ns;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kvlp_req_if.sv @@
// Input channel of the key/value line parser: one character or end mark per transaction.
// Depends on kvlp_pkg.
`default_nettype none

interface kvlp_req_if;
   import kvlp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kvlp_rsp_if.sv @@
// Result channel of the key/value line parser: one result per input transaction.
// Depends on kvlp_pkg.
`default_nettype none

interface kvlp_rsp_if;
   import kvlp_pkg::*;

   logic              valid;
   logic              ready;
   logic [ROLE_W-1:0] char_role;
   logic [SLOT_W-1:0] value_index;
   logic [POS_W-1:0]  position;
   logic              finished;
   logic [STAT_W-1:0] status;
   logic [LEN_W-1:0]  key_length;
   logic [CNT_W-1:0]  value_count;
   logic [LEN_W-1:0]  value_length;

   modport source (output valid, output char_role, output value_index, output position,
                   output finished, output status, output key_length,
                   output value_count, output value_length, input ready);
   modport sink   (input valid, input char_role, input value_index, input position,
                   input finished, input status, input key_length,
                   input value_count, input value_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kvlp_core.sv @@
// Parse core: input register, parser state and the per-character decode.
// Depends on kvlp_pkg and kvlp_req_if.
`default_nettype none

module kvlp_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   kvlp_req_if.sink                       req_chan,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      kvlp_pkg::rsp_payload_type out_data
);
   import kvlp_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              end_ff;

   // parser state
   parse_state_type   state_ff,   state_in;
   logic [POS_W-1:0]  offset_ff,  offset_in;
   logic [CNT_W-1:0]  opened_ff,  opened_in;
   logic [SLOT_W-1:0] slot_ff,    slot_in;
   logic [LEN_W-1:0]  key_len_ff, key_len_in;
   logic [LEN_W-1:0]  val_len_ff, val_len_in;
   logic              closed_ff,  closed_in;
   status_type        held_ff,    held_in;

   char_class_type    cls;
   parse_state_type   ns;
   role_type          role;
   status_type        stat;
   logic              fin;
   logic              can_open;
   logic              advance;

   assign advance        = in_valid_ff && out_ready;
   assign req_chan.ready = !in_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         char_ff <= req_chan.char_code;
         end_ff  <= req_chan.line_end;
      end
   end

   assign cls      = classify(char_ff, end_ff);
   assign ns       = next_state(state_ff, cls);
   assign can_open = opened_ff < CNT_MAX;

   // next state
   always_comb begin
      state_in = state_ff;
      if (!closed_ff) begin
         state_in = ns;
      end
   end

   // per-character outputs and counter updates
   always_comb begin
      role       = ROLE_NONE;
      stat       = STAT_OK;
      fin        = 1'b0;
      opened_in  = opened_ff;
      slot_in    = slot_ff;
      key_len_in = key_len_ff;
      val_len_in = val_len_ff;
      closed_in  = closed_ff;
      held_in    = held_ff;
      if (closed_ff) begin
         fin  = 1'b1;
         stat = held_ff;
      end else begin
         unique case (ns) inside
            ST_KBEG: begin
               key_len_in = LEN_W'(1);
               role       = ROLE_KEY_START;
            end
            ST_KRUN: begin
               key_len_in = (key_len_ff < LEN_LIMIT) ? key_len_ff + LEN_W'(1) : key_len_ff;
               role       = ROLE_KEY_MORE;
            end
            ST_VOPEN, ST_QOPEN_B, ST_VBEG_B: begin
               if (can_open) begin
                  opened_in  = opened_ff + CNT_W'(1);
                  slot_in    = opened_ff[SLOT_W-1:0];
                  val_len_in = (ns == ST_VBEG_B) ? LEN_W'(1) : '0;
                  role       = (ns == ST_VBEG_B) ? ROLE_OPENED_FIRST : ROLE_VALUE_OPENED;
               end else begin
                  stat = STAT_TOO_MANY;
               end
            end
            ST_VBEG_A, ST_QFIRST: begin
               val_len_in = LEN_W'(1);
               role       = ROLE_VALUE_FIRST;
            end
            ST_VRUN, ST_QRUN: begin
               val_len_in = (val_len_ff < LEN_LIMIT) ? val_len_ff + LEN_W'(1) : val_len_ff;
               role       = ROLE_VALUE_MORE;
            end
            ST_ERR_KEYCH:    stat = STAT_BAD_KEY_CHAR;
            ST_ERR_NOKEY:    stat = STAT_NO_KEY;
            ST_ERR_KEYBLANK: stat = STAT_KEY_BLANK;
            ST_ERR_VALCH:    stat = STAT_BAD_VALUE_CHAR;
            ST_ERR_NOQUOTE:  stat = STAT_NO_END_QUOTE;
            ST_ERR_AFTERQ:   stat = STAT_BAD_AFTER_QUOTE;
            default: ;
         endcase
         if (stat != STAT_OK || ns == ST_DONE) begin
            fin       = 1'b1;
            closed_in = 1'b1;
            held_in   = stat;
         end
      end
      offset_in = (offset_ff < POS_MAX) ? offset_ff + POS_W'(1) : offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && end_ff)) begin
         state_ff   <= ST_IDLE;
         offset_ff  <= '0;
         opened_ff  <= '0;
         slot_ff    <= '0;
         key_len_ff <= '0;
         val_len_ff <= '0;
         closed_ff  <= 1'b0;
         held_ff    <= STAT_OK;
      end else if (advance) begin
         state_ff   <= state_in;
         offset_ff  <= offset_in;
         opened_ff  <= opened_in;
         slot_ff    <= slot_in;
         key_len_ff <= key_len_in;
         val_len_ff <= val_len_in;
         closed_ff  <= closed_in;
         held_ff    <= held_in;
      end
   end

   assign out_valid              = in_valid_ff;
   assign out_data.char_role     = role;
   assign out_data.value_index   = slot_in;
   assign out_data.position      = offset_ff;
   assign out_data.finished      = fin;
   assign out_data.status        = stat;
   assign out_data.key_length    = key_len_in;
   assign out_data.value_count   = opened_in;
   assign out_data.value_length  = val_len_in;

endmodule

`default_nettype wire

@@ hw/rtl/kvlp_rsp_buf.sv @@
// Two-entry result buffer (head register plus skid entry) driving the result channel.
// Depends on kvlp_pkg and kvlp_rsp_if.
`default_nettype none

module kvlp_rsp_buf (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire kvlp_pkg::rsp_payload_type in_data,
   kvlp_rsp_if.source                     rsp_chan
);
   import kvlp_pkg::*;

   logic            head_valid_ff;
   logic            tail_valid_ff;
   rsp_payload_type head_ff;
   rsp_payload_type tail_ff;
   logic            push;
   logic            pop;

   // ready depends only on the skid entry, so no path from rsp ready back upstream
   assign in_ready = !tail_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = head_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else if (pop) begin
         if (tail_valid_ff) begin
            tail_valid_ff <= 1'b0;
         end else begin
            head_valid_ff <= push;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            tail_valid_ff <= 1'b1;
         end else begin
            head_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && tail_valid_ff) begin
         head_ff <= tail_ff;
      end else if (push && (pop || !head_valid_ff)) begin
         head_ff <= in_data;
      end
      if (push && head_valid_ff && !pop) begin
         tail_ff <= in_data;
      end
   end

   assign rsp_chan.valid        = head_valid_ff;
   assign rsp_chan.char_role    = head_ff.char_role;
   assign rsp_chan.value_index  = head_ff.value_index;
   assign rsp_chan.position     = head_ff.position;
   assign rsp_chan.finished     = head_ff.finished;
   assign rsp_chan.status       = head_ff.status;
   assign rsp_chan.key_length   = head_ff.key_length;
   assign rsp_chan.value_count  = head_ff.value_count;
   assign rsp_chan.value_length = head_ff.value_length;

endmodule

`default_nettype wire

@@ hw/rtl/key_value_line_parser.sv @@
// Top level of the key/value line parser: parse core feeding a two-entry result buffer.
// Depends on kvlp_pkg, kvlp_req_if, kvlp_rsp_if, kvlp_core and kvlp_rsp_buf.
//
// Feed one character of a "key = value, value" line per transaction, then a transaction
// with line_end set; each transaction gives exactly one result, in order, describing that
// character's role, its value slot, its offset and the running key/value lengths. Once an
// error or the end of the line is reached, finished stays set with the held status until
// the end mark, after which the parser is back in its reset state. The block takes one
// character per clock while the result side keeps up: the table lookup and counter
// updates sit between the input register and the result register, and a result is
// presented from the result register after its character has passed the input register.
// A two-entry result buffer keeps input flowing while a result waits on the output side.
`default_nettype none

module key_value_line_parser (
   input wire logic   clock,
   input wire logic   reset,
   kvlp_req_if.sink   req_chan,
   kvlp_rsp_if.source rsp_chan
);
   import kvlp_pkg::*;

   logic            core_valid;
   logic            core_ready;
   rsp_payload_type core_data;

   kvlp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_data  (core_data)
   );

   kvlp_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (core_valid),
      .in_ready (core_ready),
      .in_data  (core_data),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for key_value_line_parser: queued character lines drive the input
// channel, and every result is checked against an in-bench prediction of the parse.
// Depends on kvlp_pkg, kvlp_req_if, kvlp_rsp_if and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
   import kvlp_pkg::*;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              eol;
      logic              drain_first;   // hold until every result is back
   } line_char_type;

   logic clock;
   logic reset;

   kvlp_req_if req_chan ();
   kvlp_rsp_if rsp_chan ();

   key_value_line_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   line_char_type   pending_chars[$];
   rsp_payload_type expected_results[$];

   // predicted parser state
   parse_state_type   line_state;
   logic [POS_W-1:0]  char_pos;
   logic [CNT_W-1:0]  values_open;
   logic [SLOT_W-1:0] value_slot;
   logic [LEN_W-1:0]  key_len;
   logic [LEN_W-1:0]  value_len;
   logic              line_over;
   status_type        held_status;

   int   mismatches;
   int   chars_taken;
   int   results_checked;
   int   queued_items;
   int   lines_queued;
   int   status_hits[8];
   logic drain_pending;
   logic calm;

   // long stretch without idling on either side
   assign calm = (chars_taken >= 1300) && (chars_taken < 1600);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("key_value_line_parser regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic char_class_type class_of(input logic [CHAR_W-1:0] code,
                                               input logic eol);
      if (eol) return CLS_END;
      case (code)
         CHAR_HASH:   return CLS_HASH;
         CHAR_BLANK:  return CLS_BLANK;
         CHAR_COMMA:  return CLS_COMMA;
         CHAR_QUOTE:  return CLS_QUOTE;
         CHAR_EQUALS: return CLS_EQUALS;
         default:     return CLS_OTHER;
      endcase
   endfunction

   // columns: hash, blank, comma, quote, equals, end, other
   function automatic parse_state_type advance(input parse_state_type s,
                                               input char_class_type c);
      parse_state_type row [7];
      case (s)
         ST_NOTE: row = '{ST_NOTE, ST_NOTE, ST_NOTE, ST_NOTE, ST_NOTE, ST_DONE, ST_NOTE};
         ST_KBEG, ST_KRUN: begin
            row = '{ST_NOTE, ST_KGAP, ST_ERR_KEYCH, ST_ERR_KEYCH, ST_VOPEN, ST_DONE, ST_KRUN};
         end
         ST_KGAP: begin
            row = '{ST_NOTE, ST_KGAP, ST_ERR_KEYCH, ST_ERR_KEYCH, ST_VOPEN, ST_DONE,
                    ST_ERR_KEYBLANK};
         end
         ST_VOPEN, ST_VGAP_PRE: begin
            row = '{ST_NOTE, ST_VGAP_PRE, ST_VOPEN, ST_QOPEN_A, ST_ERR_VALCH, ST_DONE,
                    ST_VBEG_A};
         end
         ST_VBEG_A, ST_VRUN, ST_VBEG_B: begin
            row = '{ST_NOTE, ST_VGAP_POST, ST_VOPEN, ST_ERR_VALCH, ST_ERR_VALCH, ST_DONE,
                    ST_VRUN};
         end
         ST_VGAP_POST: begin
            row = '{ST_NOTE, ST_VGAP_POST, ST_VOPEN, ST_QOPEN_B, ST_ERR_VALCH, ST_DONE,
                    ST_VBEG_B};
         end
         ST_QOPEN_A, ST_QOPEN_B: begin
            row = '{ST_QFIRST, ST_QFIRST, ST_QFIRST, ST_QCLOSE, ST_QFIRST, ST_ERR_NOQUOTE,
                    ST_QFIRST};
         end
         ST_QFIRST, ST_QRUN: begin
            row = '{ST_QRUN, ST_QRUN, ST_QRUN, ST_QCLOSE, ST_QRUN, ST_ERR_NOQUOTE, ST_QRUN};
         end
         ST_QCLOSE: begin
            row = '{ST_NOTE, ST_VGAP_POST, ST_VOPEN, ST_ERR_AFTERQ, ST_ERR_AFTERQ, ST_DONE,
                    ST_ERR_AFTERQ};
         end
         default: begin
            row = '{ST_NOTE, ST_IDLE, ST_ERR_KEYCH, ST_ERR_KEYCH, ST_ERR_NOKEY, ST_DONE,
                    ST_KBEG};
         end
      endcase
      return row[c];
   endfunction

   function automatic void clear_line();
      line_state  = ST_IDLE;
      char_pos    = '0;
      values_open = '0;
      value_slot  = '0;
      key_len     = '0;
      value_len   = '0;
      line_over   = 1'b0;
      held_status = STAT_OK;
   endfunction

   // counts stay put when the value limit is already reached
   function automatic logic open_slot();
      if (values_open >= CNT_MAX) return 1'b0;
      values_open = values_open + 1'b1;
      value_slot  = SLOT_W'(values_open - 1'b1);
      value_len   = '0;
      return 1'b1;
   endfunction

   function automatic rsp_payload_type parse_char(input logic [CHAR_W-1:0] code,
                                                  input logic eol);
      rsp_payload_type res;
      parse_state_type ns;
      role_type        role;
      status_type      stat;
      logic            fin;
      role = ROLE_NONE;
      stat = STAT_OK;
      fin  = 1'b0;
      if (line_over) begin
         fin  = 1'b1;
         stat = held_status;
      end else begin
         ns = advance(line_state, class_of(code, eol));
         case (ns)
            ST_KBEG: begin
               key_len = LEN_W'(1);
               role    = ROLE_KEY_START;
            end
            ST_KRUN: begin
               key_len = (key_len < LEN_LIMIT) ? key_len + 1'b1 : key_len;
               role    = ROLE_KEY_MORE;
            end
            ST_VOPEN, ST_QOPEN_B: begin
               if (open_slot()) role = ROLE_VALUE_OPENED;
               else stat = STAT_TOO_MANY;
            end
            ST_VBEG_A, ST_QFIRST: begin
               value_len = LEN_W'(1);
               role      = ROLE_VALUE_FIRST;
            end
            ST_VRUN, ST_QRUN: begin
               value_len = (value_len < LEN_LIMIT) ? value_len + 1'b1 : value_len;
               role      = ROLE_VALUE_MORE;
            end
            ST_VBEG_B: begin
               if (open_slot()) begin
                  value_len = LEN_W'(1);
                  role      = ROLE_OPENED_FIRST;
               end else begin
                  stat = STAT_TOO_MANY;
               end
            end
            ST_ERR_KEYCH:    stat = STAT_BAD_KEY_CHAR;
            ST_ERR_NOKEY:    stat = STAT_NO_KEY;
            ST_ERR_KEYBLANK: stat = STAT_KEY_BLANK;
            ST_ERR_VALCH:    stat = STAT_BAD_VALUE_CHAR;
            ST_ERR_NOQUOTE:  stat = STAT_NO_END_QUOTE;
            ST_ERR_AFTERQ:   stat = STAT_BAD_AFTER_QUOTE;
            default: ;
         endcase
         if (stat != STAT_OK || ns == ST_DONE) begin
            fin         = 1'b1;
            line_over   = 1'b1;
            held_status = stat;
            status_hits[stat]++;
         end
         line_state = ns;
      end
      res.char_role    = role;
      res.value_index  = value_slot;
      res.position     = char_pos;
      res.finished     = fin;
      res.status       = stat;
      res.key_length   = key_len;
      res.value_count  = values_open;
      res.value_length = value_len;
      if (eol) clear_line();
      else if (char_pos < POS_MAX) char_pos = char_pos + 1'b1;
      return res;
   endfunction

   // ---------------------------------------------------------------- driver / monitor

   always @(posedge clock) begin : driver
      line_char_type next_char;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(parse_char(req_chan.char_code, req_chan.line_end));
            chars_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_chars.size() != 0
                && !(pending_chars[0].drain_first && expected_results.size() != 0)
                && (calm || $urandom_range(0, 99) >= 30)) begin
               next_char = pending_chars.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.char_code <= next_char.code;
               req_chan.line_end  <= next_char.eol;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                  input logic [15:0] want_v);
      mismatches++;
      if (mismatches <= 40) begin
         $display("%0t: result %0d %s: got %0h, expected %0h",
                  $time, results_checked, what, got_v, want_v);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.char_role    = role_type'(rsp_chan.char_role);
            got.value_index  = rsp_chan.value_index;
            got.position     = rsp_chan.position;
            got.finished     = rsp_chan.finished;
            got.status       = status_type'(rsp_chan.status);
            got.key_length   = rsp_chan.key_length;
            got.value_count  = rsp_chan.value_count;
            got.value_length = rsp_chan.value_length;
            if (expected_results.size() == 0) begin
               report_mismatch("arrived with nothing expected", got.position, '0);
            end else begin
               want = expected_results.pop_front();
               if (got.char_role !== want.char_role)
                  report_mismatch("char_role", got.char_role, want.char_role);
               if (got.value_index !== want.value_index)
                  report_mismatch("value_index", got.value_index, want.value_index);
               if (got.position !== want.position)
                  report_mismatch("position", got.position, want.position);
               if (got.finished !== want.finished)
                  report_mismatch("finished", got.finished, want.finished);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.key_length !== want.key_length)
                  report_mismatch("key_length", got.key_length, want.key_length);
               if (got.value_count !== want.value_count)
                  report_mismatch("value_count", got.value_count, want.value_count);
               if (got.value_length !== want.value_length)
                  report_mismatch("value_length", got.value_length, want.value_length);
            end
            results_checked++;
         end
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 30);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [CHAR_W-1:0] plain_byte();
      logic [CHAR_W-1:0] b;
      do b = CHAR_W'($urandom_range(0, 255));
      while (b inside {CHAR_HASH, CHAR_BLANK, CHAR_COMMA, CHAR_QUOTE, CHAR_EQUALS});
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] quoted_byte();
      logic [CHAR_W-1:0] b;
      do b = CHAR_W'($urandom_range(0, 255));
      while (b == CHAR_QUOTE);
      return b;
   endfunction

   // about half of these are separators
   function automatic logic [CHAR_W-1:0] mixed_byte();
      case ($urandom_range(0, 9))
         0:       return CHAR_HASH;
         1:       return CHAR_BLANK;
         2:       return CHAR_COMMA;
         3:       return CHAR_QUOTE;
         4:       return CHAR_EQUALS;
         default: return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_char(input logic [CHAR_W-1:0] code);
      pending_chars.push_back('{code, 1'b0, drain_pending});
      drain_pending = 1'b0;
      queued_items++;
   endtask

   // the code byte rides along on end transactions but must be ignored
   task automatic add_end();
      pending_chars.push_back('{CHAR_W'($urandom_range(0, 255)), 1'b1, drain_pending});
      drain_pending = 1'b0;
      queued_items++;
      lines_queued++;
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) add_char(s[i]);
   endtask

   task automatic queue_random_line();
      logic [CHAR_W-1:0] text[$];
      int kind;
      int nvals;
      int vmax;
      int pick;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(0, 12)) text.push_back(mixed_byte());
      end else if (kind < 20) begin
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_BLANK);
         if ($urandom_range(0, 3) != 0) begin
            text.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 6)) text.push_back(mixed_byte());
         end
      end else begin
         // key = value list, with many short values now and then to hit the value limit
         nvals = (kind < 30) ? $urandom_range(14, 18) : $urandom_range(0, 4);
         vmax  = (kind < 30) ? 1 : 6;
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_BLANK);
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6))
            text.push_back(plain_byte());
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_BLANK);
         text.push_back(CHAR_EQUALS);
         repeat ($urandom_range(0, 2)) text.push_back(CHAR_BLANK);
         for (int v = 0; v < nvals; v++) begin
            if (v > 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(1, 2)) text.push_back(CHAR_BLANK);
               end else begin
                  repeat ($urandom_range(0, 1)) text.push_back(CHAR_BLANK);
                  text.push_back(CHAR_COMMA);
                  repeat ($urandom_range(0, 1)) text.push_back(CHAR_BLANK);
               end
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               text.push_back(CHAR_QUOTE);
               repeat ($urandom_range(0, vmax)) text.push_back(quoted_byte());
               text.push_back(CHAR_QUOTE);
            end else if (pick < 9) begin
               repeat ($urandom_range(1, vmax)) text.push_back(plain_byte());
            end
         end
         repeat ($urandom_range(0, 1)) text.push_back(CHAR_BLANK);
         if ($urandom_range(0, 4) == 0) begin
            text.push_back(CHAR_HASH);
            repeat ($urandom_range(0, 5)) text.push_back(mixed_byte());
         end
         // broken lines: one character swapped, or the tail cut off
         if (kind >= 30 && kind < 45) begin
            text[$urandom_range(0, text.size() - 1)] = mixed_byte();
         end else if (kind >= 45 && kind < 52) begin
            cut = $urandom_range(0, text.size());
            while (text.size() > cut) void'(text.pop_back());
         end
      end
      foreach (text[i]) add_char(text[i]);
      add_end();
   endtask

   initial begin : stimulus
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      req_chan.line_end  = 1'b0;
      rsp_chan.ready     = 1'b0;
      drain_pending      = 1'b0;
      clear_line();

      // one line per error but too_many, closed-line items, bytes 00 and ff, comment line
      add_text("=");       add_end();
      add_text(",x");      add_end();
      add_text("k x");     add_end();
      add_text("k==");     add_end();
      add_text("k=\"");    add_char(8'h00); add_end();
      add_text("k=\"\"");  add_char(8'hFF); add_end();
      add_text("#");       add_end();

      // saturating key length and position, then a blank-separated value
      drain_pending = 1'b1;
      repeat (1030) add_char(plain_byte());
      add_char(CHAR_EQUALS);
      repeat (6) add_char(plain_byte());
      add_text(" x");
      add_end();

      while (queued_items < 1850) begin
         if (lines_queued % 40 == 20) drain_pending = 1'b1;
         queue_random_line();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d lines, %0d transactions sent, %0d results checked", lines_queued,
               chars_taken, results_checked);
      $display("lines closed by status ok..too_many: %0d %0d %0d %0d %0d %0d %0d %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
      if (mismatches == 0) begin
         $display("key_value_line_parser regression: pass");
      end else begin
         $display("key_value_line_parser regression: fail");
      end
      $finish;
   end

endmodule
